/* src/fsrlp_pkg.sv */
package fsrlp_pkg;

    // Field widths
    localparam int unsigned ADDR_W  = 18;
    localparam int unsigned COUNT_W = 14;

    // Flash ring geometry
    localparam int unsigned SECTOR_BYTES       = 4096;
    localparam int unsigned RECORD_BYTES       = 32;
    localparam int unsigned RECORDS_PER_SECTOR = 128;
    localparam int unsigned SECTOR_COUNT       = 64;

    localparam int unsigned LOG_CAPACITY = SECTOR_COUNT * RECORDS_PER_SECTOR;
    localparam int unsigned COUNT_SAT    = 8192;
    localparam int unsigned SEC_W        = $clog2(SECTOR_COUNT);
    localparam int unsigned OFFSET_W     = $clog2(SECTOR_BYTES);
    localparam int unsigned RECORD_SHIFT = $clog2(RECORD_BYTES);
    // Bytes of a sector that hold records; the rest is slack
    localparam int unsigned SECTOR_USED  = RECORDS_PER_SECTOR * RECORD_BYTES;

    // Stream widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 112;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SEC_W-1:0]   sec_t;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_POST   = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_BUFFERED = 2'd1,
        MODE_HISTORY  = 2'd2
    } read_mode_t;

    localparam logic KIND_BUFFERED = 1'b0;
    localparam logic KIND_HISTORY  = 1'b1;

endpackage

/* src/flash_sector_ring_log_pointers.sv */
// Channel  | Direction | tdata (low bit up)                         | tuser
// ---------+-----------+--------------------------------------------+------------------------
// s_*      | in        | request_count[13:0], 2 pad bits            | operation[1:0],
//          |           |                                            | request_kind[2]
// m_*      | out       | erase_request, erase_address, write_request,| read_destination[0]
//          |           | write_address, read_request, read_address, |
//          |           | busy_res, stored_count, oldest_address,    |
//          |           | newest_address, 4 pad bits                 |
//
// One word per cycle while m_tready does not stall the output: a word waits in the input
// register, its pointer update and result are worked out from it and land in the output
// register, which drives m_tvalid.
// Reset clears all pointers, the record count, the read-out and pending requests.
// A stall on m_tready holds the output word; the input register still takes one
// more word, after which s_tready drops until the output drains.
module flash_sector_ring_log_pointers
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // request_count[13:0], pad[15:14]
    input  logic [fsrlp_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation[1:0], request_kind[2]
    input  logic [fsrlp_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // erase_request[0], erase_address[18:1], write_request[19], write_address[37:20],
    // read_request[38], read_address[56:39], busy_res[57], stored_count[71:58],
    // oldest_address[89:72], newest_address[107:90], pad[111:108]
    output logic [fsrlp_pkg::M_TDATA_W-1:0]     m_tdata,
    // read_destination[0]
    output logic                                m_tuser
);

    // Input register
    logic                       in_valid_reg;
    logic [1:0]                 in_op_reg;
    logic                       in_kind_reg;
    fsrlp_pkg::count_t          in_count_reg;

    // Log state
    fsrlp_pkg::addr_t           oldest_reg, oldest_next;
    fsrlp_pkg::addr_t           newest_reg, newest_next;
    fsrlp_pkg::count_t          total_reg, total_next;
    fsrlp_pkg::addr_t           rp_reg, rp_next;
    fsrlp_pkg::count_t          remaining_reg, remaining_next;
    logic                       active_reg, active_next;
    fsrlp_pkg::read_mode_t      mode_reg, mode_next;
    logic [1:0]                 pend_flag_reg, pend_flag_next;
    fsrlp_pkg::count_t          pend_count_reg [2];
    fsrlp_pkg::count_t          pend_count_next [2];

    // Output register
    logic                       out_valid_reg;
    logic [fsrlp_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                       out_dest_reg, out_dest_next;

    logic                       out_free;
    logic                       fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_dest_reg;

    // Address of record idx counted from the oldest record
    function automatic fsrlp_pkg::addr_t record_addr(fsrlp_pkg::addr_t oldest,
                                                     fsrlp_pkg::count_t idx);
        fsrlp_pkg::sec_t sec;
        sec = fsrlp_pkg::sec_t'(oldest / fsrlp_pkg::SECTOR_BYTES)
            + fsrlp_pkg::sec_t'(idx / fsrlp_pkg::RECORDS_PER_SECTOR);
        return (fsrlp_pkg::addr_t'(sec) << fsrlp_pkg::OFFSET_W)
             | (fsrlp_pkg::addr_t'(idx % fsrlp_pkg::RECORDS_PER_SECTOR)
                << fsrlp_pkg::RECORD_SHIFT);
    endfunction

    // Next record address, skipping sector slack and wrapping
    function automatic fsrlp_pkg::addr_t advance_addr(fsrlp_pkg::addr_t rp);
        fsrlp_pkg::sec_t                sec;
        logic [fsrlp_pkg::OFFSET_W+1:0] off;
        sec = fsrlp_pkg::sec_t'(rp / fsrlp_pkg::SECTOR_BYTES);
        off = (fsrlp_pkg::OFFSET_W+2)'(rp % fsrlp_pkg::SECTOR_BYTES)
            + (fsrlp_pkg::OFFSET_W+2)'(fsrlp_pkg::RECORD_BYTES);
        if (off >= (fsrlp_pkg::OFFSET_W+2)'(fsrlp_pkg::SECTOR_USED) ||
            off + (fsrlp_pkg::OFFSET_W+2)'(fsrlp_pkg::RECORD_BYTES)
                > (fsrlp_pkg::OFFSET_W+2)'(fsrlp_pkg::SECTOR_BYTES))
        begin
            sec = sec + fsrlp_pkg::sec_t'(1);
            off = '0;
        end
        return (fsrlp_pkg::addr_t'(sec) << fsrlp_pkg::OFFSET_W)
             | fsrlp_pkg::addr_t'(off[fsrlp_pkg::OFFSET_W-1:0]);
    endfunction

    // Input register load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg    <= s_tuser[1:0];
            in_kind_reg  <= s_tuser[2];
            in_count_reg <= s_tdata[fsrlp_pkg::COUNT_W-1:0];
        end
    end

    // Per-word update of the log pointers, read-out and result
    always_comb
    begin
        logic                er;
        fsrlp_pkg::addr_t    ea;
        logic                wr;
        fsrlp_pkg::addr_t    wa;
        logic                rr;
        fsrlp_pkg::addr_t    ra;
        logic                rd;
        fsrlp_pkg::count_t   cnt_sat;
        fsrlp_pkg::count_t   n;
        fsrlp_pkg::sec_t     sec;

        oldest_next        = oldest_reg;
        newest_next        = newest_reg;
        total_next         = total_reg;
        rp_next            = rp_reg;
        remaining_next     = remaining_reg;
        active_next        = active_reg;
        mode_next          = mode_reg;
        pend_flag_next     = pend_flag_reg;
        pend_count_next[0] = pend_count_reg[0];
        pend_count_next[1] = pend_count_reg[1];
        er = 1'b0;
        ea = '0;
        wr = 1'b0;
        wa = '0;
        rr = 1'b0;
        ra = '0;
        rd = 1'b0;
        cnt_sat = '0;
        n   = '0;
        sec = '0;

        unique case (in_op_reg)
            fsrlp_pkg::OP_APPEND:
            begin
                if (total_reg < fsrlp_pkg::COUNT_W'(fsrlp_pkg::LOG_CAPACITY))
                begin
                    if ((total_reg % fsrlp_pkg::RECORDS_PER_SECTOR) == '0)
                    begin
                        // First record of a fresh sector
                        sec = fsrlp_pkg::sec_t'(oldest_reg / fsrlp_pkg::SECTOR_BYTES)
                            + fsrlp_pkg::sec_t'(total_reg / fsrlp_pkg::RECORDS_PER_SECTOR);
                        newest_next = fsrlp_pkg::addr_t'(sec) << fsrlp_pkg::OFFSET_W;
                        er = 1'b1;
                        ea = newest_next;
                    end
                    else
                    begin
                        newest_next = newest_reg
                                    + fsrlp_pkg::ADDR_W'(fsrlp_pkg::RECORD_BYTES);
                    end
                    total_next = total_reg + fsrlp_pkg::count_t'(1);
                end
                else
                begin
                    // Full: reuse the oldest sector, drop its records
                    er = 1'b1;
                    ea = oldest_reg;
                    newest_next = oldest_reg;
                    sec = fsrlp_pkg::sec_t'(oldest_reg / fsrlp_pkg::SECTOR_BYTES)
                        + fsrlp_pkg::sec_t'(1);
                    oldest_next = fsrlp_pkg::addr_t'(sec) << fsrlp_pkg::OFFSET_W;
                    total_next  = total_reg
                                - fsrlp_pkg::COUNT_W'(fsrlp_pkg::RECORDS_PER_SECTOR)
                                + fsrlp_pkg::count_t'(1);
                end
                wr = 1'b1;
                wa = newest_next;
            end

            fsrlp_pkg::OP_POST:
            begin
                cnt_sat = (in_count_reg > fsrlp_pkg::COUNT_W'(fsrlp_pkg::COUNT_SAT))
                        ? fsrlp_pkg::COUNT_W'(fsrlp_pkg::COUNT_SAT) : in_count_reg;
                pend_flag_next[in_kind_reg]  = 1'b1;
                pend_count_next[in_kind_reg] = cnt_sat;
            end

            fsrlp_pkg::OP_TICK:
            begin
                if (mode_reg == fsrlp_pkg::MODE_NONE)
                begin
                    // Take a pending request, buffered kind first
                    if (pend_flag_reg[fsrlp_pkg::KIND_BUFFERED])
                    begin
                        if (pend_count_reg[fsrlp_pkg::KIND_BUFFERED] != '0)
                        begin
                            remaining_next = pend_count_reg[fsrlp_pkg::KIND_BUFFERED];
                            mode_next      = fsrlp_pkg::MODE_BUFFERED;
                        end
                        pend_flag_next[fsrlp_pkg::KIND_BUFFERED]  = 1'b0;
                        pend_count_next[fsrlp_pkg::KIND_BUFFERED] = '0;
                    end
                    else if (pend_flag_reg[fsrlp_pkg::KIND_HISTORY])
                    begin
                        if (pend_count_reg[fsrlp_pkg::KIND_HISTORY] != '0)
                        begin
                            remaining_next = pend_count_reg[fsrlp_pkg::KIND_HISTORY];
                            mode_next      = fsrlp_pkg::MODE_HISTORY;
                        end
                        pend_flag_next[fsrlp_pkg::KIND_HISTORY]  = 1'b0;
                        pend_count_next[fsrlp_pkg::KIND_HISTORY] = '0;
                    end
                    // Start read-out, clipped to the stored count
                    if (remaining_next != '0)
                    begin
                        n = (remaining_next > total_reg) ? total_reg : remaining_next;
                        remaining_next = n;
                        rp_next        = record_addr(oldest_reg, total_reg - n);
                        active_next    = 1'b1;
                    end
                end
                if (active_next)
                begin
                    if (remaining_next != '0)
                    begin
                        rr = 1'b1;
                        ra = rp_next;
                        rd = (mode_next == fsrlp_pkg::MODE_HISTORY);
                        rp_next        = advance_addr(rp_next);
                        remaining_next = remaining_next - fsrlp_pkg::count_t'(1);
                    end
                    else
                    begin
                        active_next = 1'b0;
                        mode_next   = fsrlp_pkg::MODE_NONE;
                    end
                end
            end

            default:
            begin
                // Unknown operation: state only
            end
        endcase

        out_data_next = {4'b0, newest_next, oldest_next, total_next, active_next,
                         ra, rr, wa, wr, ea, er};
        out_dest_next = rd;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg        <= '0;
            newest_reg        <= '0;
            total_reg         <= '0;
            rp_reg            <= '0;
            remaining_reg     <= '0;
            active_reg        <= 1'b0;
            mode_reg          <= fsrlp_pkg::MODE_NONE;
            pend_flag_reg     <= '0;
            pend_count_reg[0] <= '0;
            pend_count_reg[1] <= '0;
        end
        else if (fire)
        begin
            oldest_reg        <= oldest_next;
            newest_reg        <= newest_next;
            total_reg         <= total_next;
            rp_reg            <= rp_next;
            remaining_reg     <= remaining_next;
            active_reg        <= active_next;
            mode_reg          <= mode_next;
            pend_flag_reg     <= pend_flag_next;
            pend_count_reg[0] <= pend_count_next[0];
            pend_count_reg[1] <= pend_count_next[1];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
            out_dest_reg <= out_dest_next;
        end
    end

`ifndef SYNTHESIS
    // Log never holds more than the ring can
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= fsrlp_pkg::COUNT_W'(fsrlp_pkg::LOG_CAPACITY))
    else $error("record count above log capacity");

    // A running read-out always has a destination
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (mode_reg != fsrlp_pkg::MODE_NONE))
    else $error("read-out active without mode");

    // Oldest pointer stays on a sector boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_reg % fsrlp_pkg::SECTOR_BYTES) == '0)
    else $error("oldest pointer not sector aligned");

    // A read word reports the read-out still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[38]) |-> m_tdata[57])
    else $error("read issued while not busy");
`endif

endmodule
